// ===== rtl/i2cs_pkg.sv =====
// Shared types and constants for the index to character string converter.
// Used by i2cs_cell and index_to_charset_string_top; depends on nothing else.
package i2cs_pkg;

  localparam int DATA_W             = 64;
  localparam int CHAR_W             = 8;
  localparam int LEN_W              = 4;
  localparam int RADIX_W            = CHAR_W + 1;
  localparam int CFG_INDEX_W        = 2;
  localparam int BITS_PER_CELL      = 8;
  localparam int CELLS_PER_DIGIT    = DATA_W / BITS_PER_CELL;
  localparam int MAX_LENGTH_DEFAULT = 8;

  localparam logic [LEN_W-1:0]  STRING_LENGTH_RESET = 4'd1;
  localparam logic [CHAR_W-1:0] FIRST_CHAR_RESET    = 8'd48;
  localparam logic [CHAR_W-1:0] LAST_CHAR_RESET     = 8'd57;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STRING_LENGTH = 2'd0,
    REG_FIRST_CHAR    = 2'd1,
    REG_LAST_CHAR     = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [DATA_W-1:0] quo;
    logic [CHAR_W-1:0] rem;
    logic [DATA_W-1:0] text;
  } cell_data_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [CHAR_W-1:0]  first_char;
    logic [LEN_W-1:0]   eff_len;
  } cell_cfg_t;

endpackage

// ===== rtl/i2cs_cell.sv =====
// One pipeline cell: eight restoring division steps on the running index.
// The last cell of a digit appends its character if the digit < eff_len.
// Depends on i2cs_pkg.
module i2cs_cell #(
  parameter int DIGIT     = 0,
  parameter bit LAST_STEP = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  i2cs_pkg::cell_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cs_pkg::cell_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cs_pkg::cell_data_t out_data
);

  logic                 valid;
  i2cs_pkg::cell_data_t data;
  i2cs_pkg::cell_data_t data_next;

  always_comb begin
    logic [i2cs_pkg::DATA_W-1:0]  q;
    logic [i2cs_pkg::CHAR_W-1:0]  r;
    logic [i2cs_pkg::RADIX_W-1:0] t;
    logic                         ge;
    q = in_data.quo;
    r = in_data.rem;
    for (int j = 0; j < i2cs_pkg::BITS_PER_CELL; j++) begin
      t  = {r, q[i2cs_pkg::DATA_W-1]};
      ge = (t >= cfg.radix);
      r  = ge ? i2cs_pkg::CHAR_W'(t - cfg.radix) : t[i2cs_pkg::CHAR_W-1:0];
      q  = {q[i2cs_pkg::DATA_W-2:0], ge};
    end
    data_next.quo  = q;
    data_next.rem  = r;
    data_next.text = in_data.text;
    if (LAST_STEP) begin
      if (i2cs_pkg::LEN_W'(DIGIT) < cfg.eff_len) begin
        data_next.text = {in_data.text[i2cs_pkg::DATA_W-i2cs_pkg::CHAR_W-1:0],
                          i2cs_pkg::CHAR_W'(cfg.first_char + r)};
      end
      data_next.rem = '0;
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    valid |-> ({1'b0, data.rem} < cfg.radix))
    else $error("remainder not below radix");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(data))
    else $error("cell contents changed while stalled");

  a_rem_cleared_after_digit: assert property (@(posedge clk) disable iff (rst)
    valid && LAST_STEP |-> data.rem == '0)
    else $error("remainder not cleared at end of digit");

endmodule

// ===== rtl/index_to_charset_string_top.sv =====
// Top level of the index to character string converter: configuration
// registers and the chain of division cells. Depends on i2cs_pkg, i2cs_cell.
//
// An index arrives on the s_axis channel and leaves as a packed string on the
// m_axis channel, character position 0 in the low byte, unused bytes zero.
// The alphabet runs from first_char to last_char; the configuration channel
// writes string_length (index 0), first_char (1) and last_char (2) and is
// always ready; other indices are ignored. The user must make writes only
// while the block is idle; the block itself does not enforce this.
// Each cell performs eight division steps, so one digit takes eight cells and
// the chain is 8 * MAX_LENGTH cells long. One transfer is accepted per cycle
// while the receiver is ready. Every cell is a register stage with its own
// valid bit; when the receiver stalls, results queue up in the chain and
// input transfers continue until every cell is full.
// Reset clears all valid bits and loads string_length = 1, first_char = 48
// and last_char = 57. No memory clearing pass is needed.
module index_to_charset_string_top #(
  parameter int MAX_LENGTH = i2cs_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [i2cs_pkg::DATA_W-1:0]         s_axis_tdata,   // [63:0] candidate_index
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [i2cs_pkg::DATA_W-1:0]         m_axis_tdata,   // [63:0] candidate_text
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [i2cs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [i2cs_pkg::CHAR_W-1:0]         cfg_data
);

  localparam int NUM_CELLS = MAX_LENGTH * i2cs_pkg::CELLS_PER_DIGIT;

  logic [i2cs_pkg::LEN_W-1:0]   string_length;
  logic [i2cs_pkg::CHAR_W-1:0]  first_char;
  logic [i2cs_pkg::CHAR_W-1:0]  last_char;
  logic [i2cs_pkg::CHAR_W-1:0]  hi_char;
  i2cs_pkg::cell_cfg_t          cfg;

  logic                 valid [0:NUM_CELLS];
  logic                 ready [0:NUM_CELLS];
  i2cs_pkg::cell_data_t data  [0:NUM_CELLS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      string_length <= i2cs_pkg::STRING_LENGTH_RESET;
      first_char    <= i2cs_pkg::FIRST_CHAR_RESET;
      last_char     <= i2cs_pkg::LAST_CHAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cs_pkg::REG_STRING_LENGTH: begin
          string_length <= cfg_data[i2cs_pkg::LEN_W-1:0];
        end
        i2cs_pkg::REG_FIRST_CHAR: begin
          first_char <= cfg_data;
        end
        i2cs_pkg::REG_LAST_CHAR: begin
          last_char <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign hi_char       = (last_char < first_char) ? first_char : last_char;
  assign cfg.radix     = {1'b0, hi_char} - {1'b0, first_char} + i2cs_pkg::RADIX_W'(1);
  assign cfg.first_char = first_char;
  assign cfg.eff_len   = (string_length > i2cs_pkg::LEN_W'(MAX_LENGTH)) ?
                         i2cs_pkg::LEN_W'(MAX_LENGTH) : string_length;

  assign valid[0]     = s_axis_tvalid;
  assign s_axis_tready = ready[0];
  assign data[0].quo  = s_axis_tdata;
  assign data[0].rem  = '0;
  assign data[0].text = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    i2cs_cell #(
      .DIGIT     (i / i2cs_pkg::CELLS_PER_DIGIT),
      .LAST_STEP ((i % i2cs_pkg::CELLS_PER_DIGIT) == i2cs_pkg::CELLS_PER_DIGIT - 1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_data   (data[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_data  (data[i+1])
    );
  end

  assign ready[NUM_CELLS] = m_axis_tready;
  assign m_axis_tvalid    = valid[NUM_CELLS];
  assign m_axis_tdata     = data[NUM_CELLS].text;

endmodule
